// ===== sv/ipsc_pkg.sv =====
// shared constants and types of the incremental pi speed controller
// no dependencies; compiled first

package ipsc_pkg;

    localparam int TICKS_W = 16;
    localparam int GAIN_W  = 24;
    localparam int OUT_W   = 16;
    localparam int DUTY_W  = 22;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // divider: one quotient bit per cycle, ratio < 2.0 in q12 gives 13 bits
    localparam int QUOT_W    = 13;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DIV_CNT_W = 4;

    // serial multiplier: one bit of the error operands per cycle
    localparam int OPND_W    = 15;
    localparam int MUL_STEPS = OPND_W;
    localparam int MUL_CNT_W = 4;
    localparam int ACC_W     = 27;
    localparam int THI_W     = ACC_W - 1;
    localparam int SUM_W     = 27;

    localparam logic signed [OPND_W-1:0] Q12_ONE   = 15'sd4096;
    localparam logic signed [OPND_W-1:0] ERR_SAT   = 15'sd4096;

    localparam logic [GAIN_W-1:0]  KP_RESET  = 24'd72090;
    localparam logic [GAIN_W-1:0]  KI_RESET  = 24'd131;
    localparam logic [OUT_W-1:0]   MAX_RESET = 16'h1000;
    localparam logic [OUT_W-1:0]   MIN_RESET = 16'hF000;
    localparam logic [TICKS_W-1:0] REF_RESET = 16'd4000;

    typedef enum logic [IDX_W-1:0] {
        CFG_KP_GAIN  = 3'd0,
        CFG_KI_GAIN  = 3'd1,
        CFG_OUT_MAX  = 3'd2,
        CFG_OUT_MIN  = 3'd3,
        CFG_REF_INTV = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_RUN   = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

endpackage

// ===== sv/ipsc_if.sv =====
// valid/ready channel interfaces for command and response transactions
// depends on ipsc_pkg

interface ipsc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [ipsc_pkg::TICKS_W-1:0]  hall_ticks;

    modport source (output valid, output opcode, output hall_ticks, input ready);
    modport sink   (input valid, input opcode, input hall_ticks, output ready);
endinterface

interface ipsc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ipsc_pkg::DUTY_W-1:0]  duty_increase;
    logic                                clamped;

    modport source (output valid, output duty_increase, output clamped, input ready);
    modport sink   (input valid, input duty_increase, input clamped, output ready);
endinterface

// ===== sv/ipsc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// computes floor(ticks*4096/divisor) given ticks < 2*divisor; uses ipsc_pkg

module ipsc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ipsc_pkg::TICKS_W-1:0]  ticks,
    input  logic [ipsc_pkg::TICKS_W-1:0]  divisor,
    output logic                          done,
    output logic [ipsc_pkg::QUOT_W-1:0]   quot
);

    logic                                run_reg;
    logic                                done_reg;
    logic [ipsc_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [ipsc_pkg::TICKS_W:0]          rem_reg;
    logic [ipsc_pkg::QUOT_W-1:0]         quot_reg;
    logic [ipsc_pkg::TICKS_W+1:0]        diff;
    logic                                qbit;
    logic [ipsc_pkg::TICKS_W:0]          rem_next;

    always_comb
    begin
        diff     = {1'b0, rem_reg} - {2'b00, divisor};
        qbit     = ~diff[ipsc_pkg::TICKS_W+1];
        rem_next = qbit ? diff[ipsc_pkg::TICKS_W:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ipsc_pkg::DIV_CNT_W'(ipsc_pkg::DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so one shift keeps it in range
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, ticks};
        end
        else if (run_reg)
        begin
            rem_reg  <= {rem_next[ipsc_pkg::TICKS_W-1:0], 1'b0};
            quot_reg <= {quot_reg[ipsc_pkg::QUOT_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== sv/ipsc_mul.sv =====
// bit-serial multiply-accumulate: kp*d + ki*e, one operand bit per cycle
// returns floor of the product sum over 65536; uses ipsc_pkg

module ipsc_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ipsc_pkg::GAIN_W-1:0]          kp,
    input  logic [ipsc_pkg::GAIN_W-1:0]          ki,
    input  logic signed [ipsc_pkg::OPND_W-1:0]   d,
    input  logic signed [ipsc_pkg::OPND_W-1:0]   e,
    output logic                                 done,
    output logic signed [ipsc_pkg::THI_W-1:0]    t_hi
);

    logic                                 run_reg;
    logic                                 done_reg;
    logic [ipsc_pkg::MUL_CNT_W-1:0]       cnt_reg;
    logic [ipsc_pkg::OPND_W-1:0]          d_sr_reg;
    logic [ipsc_pkg::OPND_W-1:0]          e_sr_reg;
    logic signed [ipsc_pkg::ACC_W-1:0]    acc_reg;
    logic [ipsc_pkg::GAIN_W:0]            pp;
    logic signed [ipsc_pkg::ACC_W:0]      pp_ext;
    logic signed [ipsc_pkg::ACC_W:0]      acc_sum;
    logic                                 last;

    always_comb
    begin
        last    = (cnt_reg == ipsc_pkg::MUL_CNT_W'(ipsc_pkg::MUL_STEPS - 1));
        pp      = (d_sr_reg[0] ? {1'b0, kp} : '0) + (e_sr_reg[0] ? {1'b0, ki} : '0);
        pp_ext  = signed'({{(ipsc_pkg::ACC_W - ipsc_pkg::GAIN_W){1'b0}}, pp});
        // sign bit of the operands carries negative weight
        acc_sum = {acc_reg[ipsc_pkg::ACC_W-1], acc_reg} + (last ? -pp_ext : pp_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_sr_reg <= d;
            e_sr_reg <= e;
            acc_reg  <= '0;
        end
        else if (run_reg)
        begin
            d_sr_reg <= {1'b0, d_sr_reg[ipsc_pkg::OPND_W-1:1]};
            e_sr_reg <= {1'b0, e_sr_reg[ipsc_pkg::OPND_W-1:1]};
            acc_reg  <= acc_sum[ipsc_pkg::ACC_W:1];
        end
    end

    // low product bits fall below the q16 point and are dropped (floor)
    assign done = done_reg;
    assign t_hi = acc_reg[ipsc_pkg::ACC_W-1:1];

endmodule

// ===== sv/incremental_pi_speed_controller_core.sv =====
// top level of the incremental pi speed controller with output clamp
// depends on ipsc_pkg, ipsc_if, ipsc_div, ipsc_mul
//
// usage:
//   cmd channel (valid/ready): opcode and hall_ticks; one transaction in,
//   one transaction out on the rsp channel (duty_increase, clamped).
//   cfg port: cfg_wr_en with cfg_index and cfg_data writes kp_gain,
//   ki_gain, out_max, out_min, ref_interval_ticks; write only while idle.
// sequence:
//   a run transaction passes the serial divider, the serial multiplier,
//   the clamp and the scale state; an interval of at least twice the
//   reference skips the divider. a clear goes straight to the output
//   register. one transaction is in work at a time.
// reset:
//   registers return to their documented defaults, history is zeroed,
//   both channels go idle.
// stall:
//   a finished result waits in the output register; the next command is
//   accepted meanwhile, and its result holds until the output frees up.

module incremental_pi_speed_controller_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    ipsc_cmd_if.sink                       cmd,
    ipsc_rsp_if.source                     rsp,
    input  logic                           cfg_wr_en,
    input  logic [ipsc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ipsc_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MSTART,
        S_MUL,
        S_CLAMP,
        S_SCALE,
        S_DONE
    } state_t;

    state_t                                  state_reg;

    logic [ipsc_pkg::GAIN_W-1:0]             kp_reg;
    logic [ipsc_pkg::GAIN_W-1:0]             ki_reg;
    logic signed [ipsc_pkg::OUT_W-1:0]       out_max_reg;
    logic signed [ipsc_pkg::OUT_W-1:0]       out_min_reg;
    logic [ipsc_pkg::TICKS_W-1:0]            ref_reg;

    logic signed [ipsc_pkg::OUT_W-1:0]       prev_err_reg;
    logic signed [ipsc_pkg::OUT_W-1:0]       prev_out_reg;

    logic [ipsc_pkg::TICKS_W-1:0]            ticks_reg;
    logic signed [ipsc_pkg::OPND_W-1:0]      e_reg;
    logic signed [ipsc_pkg::SUM_W-1:0]       sum_reg;
    logic signed [ipsc_pkg::OUT_W-1:0]       res_reg;
    logic                                    lim_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0]      duty_reg;
    logic                                    div_start_reg;
    logic                                    mul_start_reg;

    logic                                    out_valid_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0]      out_duty_reg;
    logic                                    out_clamp_reg;

    logic                                    div_done;
    logic [ipsc_pkg::QUOT_W-1:0]             div_quot;
    logic                                    mul_done;
    logic signed [ipsc_pkg::THI_W-1:0]       mul_t_hi;

    logic                                    cmd_fire;
    logic                                    rsp_fire;
    logic                                    sat;
    logic signed [ipsc_pkg::OUT_W-1:0]       err_diff;
    logic signed [ipsc_pkg::SUM_W-1:0]       max_ext;
    logic signed [ipsc_pkg::SUM_W-1:0]       min_ext;
    logic signed [ipsc_pkg::DUTY_W-1:0]      res_ext;

    always_comb
    begin
        cmd_fire = cmd.valid && cmd.ready;
        rsp_fire = rsp.valid && rsp.ready;
        sat      = {1'b0, cmd.hall_ticks} >= {ref_reg, 1'b0};
        err_diff = ipsc_pkg::OUT_W'(e_reg) - prev_err_reg;
        max_ext  = ipsc_pkg::SUM_W'(out_max_reg);
        min_ext  = ipsc_pkg::SUM_W'(out_min_reg);
        res_ext  = ipsc_pkg::DUTY_W'(res_reg);
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.duty_increase = out_duty_reg;
    assign rsp.clamped       = out_clamp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= ipsc_pkg::KP_RESET;
            ki_reg      <= ipsc_pkg::KI_RESET;
            out_max_reg <= ipsc_pkg::MAX_RESET;
            out_min_reg <= ipsc_pkg::MIN_RESET;
            ref_reg     <= ipsc_pkg::REF_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ipsc_pkg::CFG_KP_GAIN:  kp_reg      <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::CFG_KI_GAIN:  ki_reg      <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::CFG_OUT_MAX:  out_max_reg <= cfg_data[ipsc_pkg::OUT_W-1:0];
                ipsc_pkg::CFG_OUT_MIN:  out_min_reg <= cfg_data[ipsc_pkg::OUT_W-1:0];
                ipsc_pkg::CFG_REF_INTV: ref_reg     <= cfg_data[ipsc_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, history and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_err_reg  <= '0;
            prev_out_reg  <= '0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            if (rsp_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        ticks_reg <= cmd.hall_ticks;
                        if (cmd.opcode == ipsc_pkg::OP_CLEAR)
                        begin
                            prev_err_reg <= '0;
                            prev_out_reg <= '0;
                            duty_reg     <= '0;
                            lim_reg      <= 1'b0;
                            state_reg    <= S_DONE;
                        end
                        else if (sat)
                        begin
                            e_reg     <= ipsc_pkg::ERR_SAT;
                            state_reg <= S_MSTART;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        e_reg     <= signed'({2'b00, div_quot}) - ipsc_pkg::Q12_ONE;
                        state_reg <= S_MSTART;
                    end
                end
                S_MSTART:
                begin
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        sum_reg   <= ipsc_pkg::SUM_W'(prev_out_reg)
                                   + ipsc_pkg::SUM_W'(mul_t_hi);
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    // crossed limits: a sum above the upper limit takes it, any other sum the lower
                    if (sum_reg > max_ext)
                    begin
                        res_reg      <= out_max_reg;
                        prev_out_reg <= out_max_reg;
                        lim_reg      <= 1'b1;
                    end
                    else if (sum_reg < min_ext)
                    begin
                        res_reg      <= out_min_reg;
                        prev_out_reg <= out_min_reg;
                        lim_reg      <= 1'b1;
                    end
                    else
                    begin
                        res_reg      <= sum_reg[ipsc_pkg::OUT_W-1:0];
                        prev_out_reg <= sum_reg[ipsc_pkg::OUT_W-1:0];
                        lim_reg      <= 1'b0;
                    end
                    prev_err_reg <= ipsc_pkg::OUT_W'(e_reg);
                    state_reg    <= S_SCALE;
                end
                S_SCALE:
                begin
                    // times 50 as 32 + 16 + 2
                    duty_reg  <= (res_ext <<< 5) + (res_ext <<< 4) + (res_ext <<< 1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_duty_reg  <= duty_reg;
                        out_clamp_reg <= lim_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ipsc_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .ticks   (ticks_reg),
        .divisor (ref_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    ipsc_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .kp    (kp_reg),
        .ki    (ki_reg),
        .d     (err_diff[ipsc_pkg::OPND_W-1:0]),
        .e     (e_reg),
        .done  (mul_done),
        .t_hi  (mul_t_hi)
    );

endmodule

// ===== test/tb_incremental_pi_speed_controller_core.sv =====
// self-checking testbench for incremental_pi_speed_controller_core
// depends on ipsc_pkg, ipsc_if and the controller rtl; each response transaction is checked
// against the predictor or a typed expected value, in the order the commands were accepted
`timescale 1ns / 1ps

module tb_incremental_pi_speed_controller_core;
    import ipsc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int LAT_PAD      = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_MODES   = 3;
    localparam int RAND_BLOCKS  = 5;
    localparam int BLOCK_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RATIO_ONE    = 4096;
    localparam int RATIO_SAT    = 8192;
    localparam int DUTY_SCALE   = 50;
    localparam int DIR_ROWS     = 39;

    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty;
        logic                     clamped;
    } duty_rec_t;

    typedef struct {
        logic                is_cfg;
        logic [IDX_W-1:0]    idx;
        logic [CFG_W-1:0]    data;
        opcode_t             op;
        logic [TICKS_W-1:0]  ticks;
        logic                typed;
        int                  want_duty;
        logic                want_clamp;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    ipsc_cmd_if cmd_ch ();
    ipsc_rsp_if rsp_ch ();

    incremental_pi_speed_controller_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the controller history
    logic [GAIN_W-1:0]         gain_kp;
    logic [GAIN_W-1:0]         gain_ki;
    logic signed [OUT_W-1:0]   clamp_hi;
    logic signed [OUT_W-1:0]   clamp_lo;
    logic [TICKS_W-1:0]        ref_ticks;
    logic signed [OUT_W-1:0]   err_hist;
    logic signed [OUT_W-1:0]   out_hist;

    duty_rec_t duty_pending_q[$];
    int        err_count;
    int        rsp_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_left;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd4000,  1'b1, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65535, 1'b1, 204800,   1'b1},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_CLEAR, 16'd0,     1'b1, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b1, -204800,  1'b1},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd8000,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd7999,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd4001,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd3999,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_CLEAR, 16'd65535, 1'b1, 0,        1'b0},
        '{1'b1, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_KI_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd12345, 1'b0, 0,        1'b0},
        '{1'b1, CFG_KP_GAIN,  24'hFFFFFF, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_KI_GAIN,  24'hFFFFFF, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_OUT_MAX,  24'h007FFF, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_OUT_MIN,  24'h008000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65535, 1'b1, 1638350,  1'b1},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b1, -1638400, 1'b1},
        '{1'b1, CFG_REF_INTV, 24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65535, 1'b0, 0,        1'b0},
        '{1'b1, CFG_REF_INTV, 24'h000001, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd1,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd2,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_REF_INTV, 24'h00FFFF, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65535, 1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65534, 1'b0, 0,        1'b0},
        '{1'b1, CFG_KP_GAIN,  24'd72090,  OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_KI_GAIN,  24'd131,    OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_OUT_MAX,  24'hA5FF9C, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_OUT_MIN,  24'h5A0064, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd4000,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd65535, 1'b0, 0,        1'b0},
        '{1'b1, CFG_SPARE_LO, 24'hFFFFFF, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b1, CFG_SPARE_HI, 24'h000000, OP_RUN,   16'd0,     1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_RUN,   16'd4000,  1'b0, 0,        1'b0},
        '{1'b0, CFG_KP_GAIN,  24'h000000, OP_CLEAR, 16'd0,     1'b1, 0,        1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_incremental_pi_speed_controller_core: FAIL");
        $finish;
    end

    function automatic duty_rec_t predict_pi_step(input opcode_t op,
                                                  input logic [TICKS_W-1:0] ticks);
        int                      ratio;
        int                      err_now;
        longint                  t_acc;
        longint                  sum;
        logic signed [OUT_W-1:0] res;
        duty_rec_t               rec;
        rec.clamped = 1'b0;
        if (op == OP_CLEAR)
        begin
            err_hist = '0;
            out_hist = '0;
            rec.duty = '0;
            return rec;
        end
        if (int'(ticks) >= 2 * int'(ref_ticks))
            ratio = RATIO_SAT;
        else
            ratio = (int'(ticks) * RATIO_ONE) / int'(ref_ticks);
        err_now = ratio - RATIO_ONE;
        t_acc = longint'(gain_kp) * longint'(err_now - int'(err_hist))
              + longint'(gain_ki) * longint'(err_now);
        sum = longint'(out_hist) + (t_acc >>> 16);
        if (sum > longint'(clamp_hi))
        begin
            res = clamp_hi;
            rec.clamped = 1'b1;
        end
        else if (sum < longint'(clamp_lo))
        begin
            res = clamp_lo;
            rec.clamped = 1'b1;
        end
        else
        begin
            res = sum[OUT_W-1:0];
        end
        err_hist = err_now[OUT_W-1:0];
        out_hist = res;
        rec.duty = DUTY_W'(int'(res) * DUTY_SCALE);
        return rec;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at response %0d: got %0d, want %0d",
                 what, rsp_count, got, want);
        err_count++;
    endtask

    // called at a falling edge; leaves valid high after the transaction
    task automatic send_cmd(input opcode_t op, input logic [TICKS_W-1:0] ticks,
                            input logic typed, input duty_rec_t typed_rec);
        duty_rec_t rec;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.hall_ticks <= ticks;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        rec = predict_pi_step(op, ticks);
        duty_pending_q.push_back(typed ? typed_rec : rec);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (duty_pending_q.size() != 0)
            @(negedge clk);
        repeat (LAT_PAD) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_KP_GAIN:  gain_kp   = data[GAIN_W-1:0];
            CFG_KI_GAIN:  gain_ki   = data[GAIN_W-1:0];
            CFG_OUT_MAX:  clamp_hi  = data[OUT_W-1:0];
            CFG_OUT_MIN:  clamp_lo  = data[OUT_W-1:0];
            CFG_REF_INTV: ref_ticks = data[TICKS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_random_cfg();
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [OUT_W-1:0]   hi;
        logic [OUT_W-1:0]   lo;
        logic [TICKS_W-1:0] rt;
        case ($urandom_range(0, 5))
            0:       kp = '0;
            1:       kp = '1;
            2:       kp = GAIN_W'($urandom);
            default: kp = GAIN_W'($urandom_range(200000, 20000));
        endcase
        case ($urandom_range(0, 5))
            0:       ki = '0;
            1:       ki = '1;
            2:       ki = GAIN_W'($urandom);
            default: ki = GAIN_W'($urandom_range(20000, 0));
        endcase
        case ($urandom_range(0, 4))
            0:
            begin
                hi = 16'h7FFF;
                lo = 16'h8000;
            end
            1:
            begin
                hi = OUT_W'($urandom);
                lo = OUT_W'($urandom);
            end
            default:
            begin
                hi = OUT_W'($urandom_range(20000, 0));
                lo = OUT_W'(-int'($urandom_range(20000, 0)));
            end
        endcase
        case ($urandom_range(0, 7))
            0:       rt = '0;
            1:       rt = 16'd1;
            2:       rt = '1;
            default: rt = TICKS_W'($urandom_range(16000, 100));
        endcase
        cfg_write(CFG_KP_GAIN, kp);
        cfg_write(CFG_KI_GAIN, ki);
        cfg_write(CFG_OUT_MAX, {8'($urandom), hi});
        cfg_write(CFG_OUT_MIN, {8'($urandom), lo});
        cfg_write(CFG_REF_INTV, {8'($urandom), rt});
        if ($urandom_range(0, 2) == 0)
            cfg_write(IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), CFG_W'($urandom));
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        duty_rec_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (duty_pending_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", rsp_ch.duty_increase, 0);
            end
            else
            begin
                want = duty_pending_q.pop_front();
                if (rsp_ch.duty_increase !== want.duty)
                    report_mismatch("duty_increase", rsp_ch.duty_increase, want.duty);
                if (rsp_ch.clamped !== want.clamped)
                    report_mismatch("clamped", rsp_ch.clamped, want.clamped);
            end
            rsp_count++;
        end
    end

    initial
    begin
        int                 lo_t;
        int                 hi_t;
        int                 twice;
        opcode_t            op;
        logic [TICKS_W-1:0] ticks;
        duty_rec_t          typed_rec;

        err_count         = 0;
        rsp_count         = 0;
        hold_left         = 0;
        send_idle_pct     = 13;
        recv_stall_pct    = 77;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_RUN;
        cmd_ch.hall_ticks = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        gain_kp           = KP_RESET;
        gain_ki           = KI_RESET;
        clamp_hi          = MAX_RESET;
        clamp_lo          = MIN_RESET;
        ref_ticks         = REF_RESET;
        err_hist          = '0;
        out_hist          = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows: reset values, extremes, zero reference, crossed limits, clear
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].is_cfg)
            begin
                wait_idle();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end
            else
            begin
                typed_rec.duty    = DUTY_W'(dir_rows[r].want_duty);
                typed_rec.clamped = dir_rows[r].want_clamp;
                send_cmd(dir_rows[r].op, dir_rows[r].ticks, dir_rows[r].typed, typed_rec);
            end
        end

        typed_rec = '0;
        for (int m = 0; m < RAND_MODES; m++)
        begin
            case (m)
                0:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 77;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int b = 0; b < RAND_BLOCKS; b++)
            begin
                wait_idle();
                apply_random_cfg();
                // long output stall while commands keep coming
                if (m == RAND_MODES - 1 && b == 0)
                    hold_left = HOLD_CYCLES;
                for (int i = 0; i < BLOCK_ITEMS; i++)
                begin
                    twice = 2 * int'(ref_ticks);
                    case ($urandom_range(0, 7))
                        0:       ticks = TICKS_W'($urandom);
                        1:       ticks = (twice > 65535) ? '1 : TICKS_W'(twice);
                        2:       ticks = (twice == 0) ? '0 :
                                         ((twice - 1 > 65535) ? '1 : TICKS_W'(twice - 1));
                        default:
                        begin
                            lo_t  = int'(ref_ticks) / 2;
                            hi_t  = int'(ref_ticks) + int'(ref_ticks) / 2;
                            if (hi_t > 65535)
                                hi_t = 65535;
                            ticks = TICKS_W'($urandom_range(hi_t, lo_t));
                        end
                    endcase
                    op = ($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_RUN;
                    send_cmd(op, ticks, 1'b0, typed_rec);
                end
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("tb_incremental_pi_speed_controller_core: PASS");
        else
            $display("tb_incremental_pi_speed_controller_core: FAIL");
        $finish;
    end

endmodule
